### hw/rtl/ute_pkg.sv
// Shared types, codes and helpers for the UTF-8 / escape to UTF-16 decoder.
// Used by ute_front, ute_queue, ute_back and the top level.
package ute_pkg;

	localparam int ACC_W     = 28;
	localparam int MAX_RES   = 3;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [6:0] MAX_UNITS_RST = 7'd64;

	// result kinds
	localparam logic [1:0] KIND_UNIT   = 2'd0;
	localparam logic [1:0] KIND_DONE   = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	// reject reasons
	localparam logic [2:0] ERR_ESC     = 3'd0;
	localparam logic [2:0] ERR_UTF8    = 3'd1;
	localparam logic [2:0] ERR_FORBID  = 3'd2;
	localparam logic [2:0] ERR_LONG    = 3'd3;
	localparam logic [2:0] ERR_EMPTY   = 3'd4;

	// special bytes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	localparam logic [ACC_W-1:0] CP_MAX    = ACC_W'(32'h10FFFF);
	localparam logic [ACC_W-1:0] CP_SUR_LO = ACC_W'(32'hD800);
	localparam logic [ACC_W-1:0] CP_SUR_HI = ACC_W'(32'hDFFF);
	localparam logic [ACC_W-1:0] CP_SUPP   = ACC_W'(32'h10000);
	localparam logic [15:0]      HI_BASE   = 16'hD800;
	localparam logic [15:0]      LO_BASE   = 16'hDC00;

	typedef enum logic [2:0] {
		M_NORMAL = 3'd0,
		M_CONT   = 3'd1,
		M_BS     = 3'd2,
		M_BSU    = 3'd3,
		M_ESC    = 3'd4,
		M_DROP   = 3'd5
	} mode_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] code_unit;
		logic [2:0]  error_code;
		logic [6:0]  unit_count;
		logic        last;
	} res_t;

	// all results caused by one byte, in order; n of them are meaningful
	typedef struct packed {
		logic [1:0] n;
		res_t [MAX_RES-1:0] res;
	} bundle_t;

	function automatic res_t mk_res(logic [1:0] kind, logic [15:0] unit,
			logic [2:0] err, logic [6:0] cnt, logic last);
		res_t r;
		r.kind       = kind;
		r.code_unit  = unit;
		r.error_code = err;
		r.unit_count = cnt;
		r.last       = last;
		return r;
	endfunction

	// {valid, value} of an ASCII hex digit, either case
	function automatic logic [4:0] hex_digit(logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39)
			r = {1'b1, 4'(b - 8'h30)};
		else if (b >= 8'h61 && b <= 8'h66)
			r = {1'b1, 4'(b - 8'h57)};
		else if (b >= 8'h41 && b <= 8'h46)
			r = {1'b1, 4'(b - 8'h37)};
		return r;
	endfunction

endpackage

### hw/rtl/ute_front.sv
// Front end: takes one byte per transfer, runs the decode state and builds
// the bundle of results that byte causes. Depends on ute_pkg.
module ute_front import ute_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       cfg_wr_en,
	input  logic [6:0] cfg_wr_data,
	input  logic       q_full,
	output logic       q_push,
	output bundle_t    q_data
);

	mode_t            mode_q, nx_mode;
	logic [ACC_W-1:0] acc_q, nx_acc, cp, acc_cont;
	logic [1:0]       cont_q, nx_cont, cont_dec;
	logic [2:0]       hex_q, nx_hex;
	logic [6:0]       units_q, u;
	logic [6:0]       max_q;
	logic [1:0]       nres;
	bundle_t          bnd;
	logic             alive, at_end, pfx_bs, pfx_u, main_normal, cp_go, fin;
	logic [4:0]       hv;
	logic [19:0]      sc;
	logic             accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept && (nres != 2'd0);
	assign q_data   = bnd;

	always_comb begin
		nx_mode     = mode_q;
		nx_acc      = acc_q;
		nx_cont     = cont_q;
		nx_hex      = hex_q;
		u           = units_q;
		nres        = 2'd0;
		bnd         = '0;
		alive       = 1'b1;
		fin         = 1'b0;
		at_end      = (in_byte == CH_NUL);
		pfx_bs      = 1'b0;
		pfx_u       = 1'b0;
		main_normal = 1'b0;
		cp_go       = 1'b0;
		cp          = '0;
		acc_cont    = {acc_q[ACC_W-7:0], in_byte[5:0]};
		cont_dec    = cont_q - 2'd1;
		hv          = hex_digit(in_byte);
		sc          = '0;

		case (mode_q)
			M_BS: begin
				if (in_byte == CH_U) begin
					nx_mode = M_BSU;
				end else begin
					pfx_bs      = 1'b1;
					main_normal = 1'b1;
					nx_mode     = M_NORMAL;
				end
			end
			M_BSU: begin
				if (in_byte == CH_LBRACE) begin
					nx_mode = M_ESC;
					nx_acc  = '0;
					nx_hex  = '0;
				end else begin
					pfx_bs      = 1'b1;
					pfx_u       = 1'b1;
					main_normal = 1'b1;
					nx_mode     = M_NORMAL;
				end
			end
			M_CONT: begin
				if (in_byte[7:6] != 2'b10) begin
					bnd.res[nres] = mk_res(KIND_REJECT, '0, ERR_UTF8, '0, 1'b1);
					nres  = nres + 2'd1;
					alive = 1'b0;
				end else begin
					nx_cont = cont_dec;
					if (cont_dec == 2'd0) begin
						nx_mode = M_NORMAL;
						nx_acc  = '0;
						cp_go   = 1'b1;
						cp      = acc_cont;
					end else begin
						nx_acc = acc_cont;
					end
				end
			end
			M_ESC: begin
				if (hex_q < 3'd7 && hv[4]) begin
					nx_acc = {acc_q[ACC_W-5:0], hv[3:0]};
					nx_hex = hex_q + 3'd1;
				end else if (in_byte == CH_RBRACE && hex_q != 3'd0) begin
					nx_mode = M_NORMAL;
					nx_acc  = '0;
					nx_hex  = '0;
					cp_go   = 1'b1;
					cp      = acc_q;
				end else begin
					bnd.res[nres] = mk_res(KIND_REJECT, '0, ERR_ESC, '0, 1'b1);
					nres  = nres + 2'd1;
					alive = 1'b0;
				end
			end
			M_DROP: begin
				if (at_end)
					nx_mode = M_NORMAL;
			end
			default: begin
				main_normal = 1'b1;
				nx_mode     = M_NORMAL;
			end
		endcase

		// held literals go out first
		if (pfx_bs) begin
			if (({1'b0, u} + 8'd1) > {1'b0, max_q}) begin
				bnd.res[nres] = mk_res(KIND_REJECT, '0, ERR_LONG, '0, 1'b1);
				nres  = nres + 2'd1;
				alive = 1'b0;
			end else begin
				bnd.res[nres] = mk_res(KIND_UNIT, {8'h00, CH_BSLASH}, '0, '0, 1'b0);
				nres = nres + 2'd1;
				u    = u + 7'd1;
			end
		end
		if (alive && pfx_u) begin
			if (({1'b0, u} + 8'd1) > {1'b0, max_q}) begin
				bnd.res[nres] = mk_res(KIND_REJECT, '0, ERR_LONG, '0, 1'b1);
				nres  = nres + 2'd1;
				alive = 1'b0;
			end else begin
				bnd.res[nres] = mk_res(KIND_UNIT, {8'h00, CH_U}, '0, '0, 1'b0);
				nres = nres + 2'd1;
				u    = u + 7'd1;
			end
		end

		if (alive && main_normal) begin
			if (at_end) begin
				if (u == 7'd0) begin
					bnd.res[nres] = mk_res(KIND_REJECT, '0, ERR_EMPTY, '0, 1'b1);
					nres  = nres + 2'd1;
					alive = 1'b0;
				end else begin
					bnd.res[nres] = mk_res(KIND_DONE, '0, '0, u, 1'b1);
					nres = nres + 2'd1;
					fin  = 1'b1;
				end
			end else if (in_byte == CH_BSLASH) begin
				nx_mode = M_BS;
			end else if (!in_byte[7]) begin
				cp_go = 1'b1;
				cp    = ACC_W'(in_byte);
			end else if (in_byte[7:5] == 3'b110) begin
				nx_acc  = ACC_W'(in_byte[4:0]);
				nx_cont = 2'd1;
				nx_mode = M_CONT;
			end else if (in_byte[7:4] == 4'b1110) begin
				nx_acc  = ACC_W'(in_byte[3:0]);
				nx_cont = 2'd2;
				nx_mode = M_CONT;
			end else if (in_byte[7:3] == 5'b11110) begin
				nx_acc  = ACC_W'(in_byte[2:0]);
				nx_cont = 2'd3;
				nx_mode = M_CONT;
			end else begin
				bnd.res[nres] = mk_res(KIND_REJECT, '0, ERR_UTF8, '0, 1'b1);
				nres  = nres + 2'd1;
				alive = 1'b0;
			end
		end

		if (alive && cp_go) begin
			if (cp == '0 || cp > CP_MAX || (cp >= CP_SUR_LO && cp <= CP_SUR_HI)) begin
				bnd.res[nres] = mk_res(KIND_REJECT, '0, ERR_FORBID, '0, 1'b1);
				nres  = nres + 2'd1;
				alive = 1'b0;
			end else if (cp >= CP_SUPP) begin
				if (({1'b0, u} + 8'd2) > {1'b0, max_q}) begin
					bnd.res[nres] = mk_res(KIND_REJECT, '0, ERR_LONG, '0, 1'b1);
					nres  = nres + 2'd1;
					alive = 1'b0;
				end else begin
					sc = 20'(cp - CP_SUPP);
					bnd.res[nres] = mk_res(KIND_UNIT, HI_BASE + {6'd0, sc[19:10]},
						'0, '0, 1'b0);
					nres = nres + 2'd1;
					bnd.res[nres] = mk_res(KIND_UNIT, LO_BASE + {6'd0, sc[9:0]},
						'0, '0, 1'b0);
					nres = nres + 2'd1;
					u    = u + 7'd2;
				end
			end else begin
				if (({1'b0, u} + 8'd1) > {1'b0, max_q}) begin
					bnd.res[nres] = mk_res(KIND_REJECT, '0, ERR_LONG, '0, 1'b1);
					nres  = nres + 2'd1;
					alive = 1'b0;
				end else begin
					bnd.res[nres] = mk_res(KIND_UNIT, cp[15:0], '0, '0, 1'b0);
					nres = nres + 2'd1;
					u    = u + 7'd1;
				end
			end
		end

		if (!alive) begin
			nx_acc  = '0;
			nx_cont = '0;
			nx_hex  = '0;
			u       = '0;
			nx_mode = at_end ? M_NORMAL : M_DROP;
		end else if (fin) begin
			nx_acc  = '0;
			nx_cont = '0;
			nx_hex  = '0;
			u       = '0;
			nx_mode = M_NORMAL;
		end
		bnd.n = nres;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_NORMAL;
			acc_q   <= '0;
			cont_q  <= '0;
			hex_q   <= '0;
			units_q <= '0;
		end else if (accept) begin
			mode_q  <= nx_mode;
			acc_q   <= nx_acc;
			cont_q  <= nx_cont;
			hex_q   <= nx_hex;
			units_q <= u;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_UNITS_RST;
		end else if (cfg_wr_en) begin
			max_q <= cfg_wr_data;
		end
	end

	// a pending multibyte sequence always has bytes left to take
	a_cont_left: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == M_CONT |-> cont_q != 2'd0)
		else $error("continuation mode with no bytes left");

	// a rejected string leaves no unit count behind while dropping
	a_drop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == M_DROP |-> units_q == 7'd0)
		else $error("unit count kept across rejection");

endmodule

### hw/rtl/ute_queue.sv
// Short queue of result bundles between the front and back ends.
// Depends on ute_pkg.
module ute_queue import ute_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	output logic    full,
	input  logic    pop,
	output logic    head_valid,
	output bundle_t head
);

	bundle_t             slot_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign full       = (cnt_q == QCNT_W'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("bundle written into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("bundle popped from empty queue");

endmodule

### hw/rtl/ute_back.sv
// Back end: walks the head bundle one result per cycle, while the output is not
// stalled, into the output register. Depends on ute_pkg.
module ute_back import ute_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    head_valid,
	input  bundle_t head,
	output logic    pop,
	output logic    out_valid,
	input  logic    out_ready,
	output res_t    out_res
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	res_t       out_q;
	logic       load, at_tail;

	assign load      = head_valid && (!out_valid_q || out_ready);
	assign at_tail   = (idx_q == head.n - 2'd1);
	assign pop       = load && at_tail;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk) begin
		if (load)
			out_q <= head.res[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (load)
				idx_q <= at_tail ? 2'd0 : idx_q + 2'd1;
		end
	end

	// a bundle half walked stays at the head until its last result
	a_mid_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd0 |-> head_valid && idx_q < head.n)
		else $error("result index past bundle");

	a_no_empty: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> head.n != 2'd0)
		else $error("empty bundle queued");

endmodule

### hw/rtl/utf8_escape_to_utf16_decoder.sv
// Top level of the UTF-8 and \u{...} escape to UTF-16 decoder.
// Depends on ute_pkg, ute_front, ute_queue, ute_back.
//
//  channel  handshake              payload
//  in       in_valid / in_ready    in_byte
//  out      out_valid / out_ready  kind, code_unit, error_code, unit_count, last
//  cfg      cfg_wr_en              cfg_wr_data (max_units)
//
// One byte per cycle while each byte yields at most one result and out_ready is high.
// A byte that yields more results is drained by the back end one result per cycle from
// a 2-deep queue; a run of such bytes fills the queue and drops in_ready.
// Results reach out_valid through a queue slot and then the output register.
// Reset clears decode state, the queue and the output valid; max_units to 64.
// Output stalls back up through the queue to in_ready.
module utf8_escape_to_utf16_decoder import ute_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [15:0] code_unit,
	output logic [2:0]  error_code,
	output logic [6:0]  unit_count,
	output logic        last,
	input  logic        cfg_wr_en,
	input  logic [6:0]  cfg_wr_data
);

	logic    q_full, q_push, q_pop, head_valid;
	bundle_t q_data, head;
	res_t    out_res;

	ute_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_data)
	);

	ute_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_data),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	ute_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_res    (out_res)
	);

	assign kind       = out_res.kind;
	assign code_unit  = out_res.code_unit;
	assign error_code = out_res.error_code;
	assign unit_count = out_res.unit_count;
	assign last       = out_res.last;

endmodule
